FILE: rtl/sqe_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sqe_pkg
// Types and constants shared by the scalar quantizer encoder modules.
// ---------------------------------------------------------------------------
package sqe_pkg;

  localparam int unsigned SlotW = 8;
  localparam logic [3:0] NibbleMask = 4'h0F;
  localparam int unsigned NibbleShift = 4;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_ENCODE = 1'b1
  } opcode_e;

  typedef enum logic {
    REG_CODE_WIDTH = 1'b0,
    REG_DIM_COUNT  = 1'b1
  } reg_index_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } search_state_e;

  typedef struct packed {
    logic        opcode;
    logic [6:0]  component;
    logic [7:0]  slot;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic [6:0] byte_index;
    logic       vector_last;
  } out_item_t;

  // Job handed from the front end to the search engine.
  typedef struct packed {
    logic [6:0]  component;
    logic [31:0] value;
    logic        wide;
    logic        last;
    logic        emit_even;
  } job_t;

  function automatic logic [31:0] order_key(input logic [31:0] x);
    logic [31:0] y;
    y = (x == 32'h8000_0000) ? 32'h0 : x;
    return y[31] ? ~y : (y | 32'h8000_0000);
  endfunction

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'h0);
  endfunction

endpackage

FILE: rtl/sqe_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sqe_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module sqe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

FILE: rtl/sqe_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sqe_front
// Classifies incoming words: loads, dropped encodes and search jobs.
// ---------------------------------------------------------------------------
module sqe_front
  import sqe_pkg::*;
#(
  parameter int unsigned MaxDim = 128
) (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  input  logic       code_width_sel_i,
  input  logic [7:0] dim_count_i,
  input  logic       ram_busy_i,
  input  logic       job_ready_i,
  output logic       job_valid_o,
  output job_t       job_o,
  output logic       load_we_o
);
  localparam int unsigned DimCap = (MaxDim < 128) ? MaxDim : 128;
  logic [7:0] dims;
  logic       in_range, is_enc, comp_ok;

  always_comb begin
    dims = dim_count_i;
    if (dims == 8'd0) dims = 8'd1;
    if (dims > 8'(DimCap)) dims = 8'(DimCap);
  end

  assign is_enc   = (in_data_i.opcode == OP_ENCODE);
  assign in_range = {1'b0, in_data_i.component} < dims;
  assign comp_ok  = (32'(in_data_i.component) < MaxDim) && (in_data_i.slot != 8'hFF);

  // Loads share the memory port with the search, so they wait while it runs.
  assign in_ready_o  = is_enc ? (job_ready_i || !in_range) : !ram_busy_i;
  assign load_we_o   = in_valid_i && in_ready_o && !is_enc && comp_ok;
  assign job_valid_o = in_valid_i && is_enc && in_range;

  always_comb begin
    job_o.component = in_data_i.component;
    job_o.value     = in_data_i.value;
    job_o.wide      = code_width_sel_i;
    job_o.last      = ({1'b0, in_data_i.component} == dims - 8'd1);
    job_o.emit_even = 1'b0;
    job_o.emit_even = job_o.last;
  end
endmodule

FILE: rtl/sqe_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sqe_back
// Upper-bound binary search over one dimension's boundaries, nibble packing
// and the output register.
// ---------------------------------------------------------------------------
module sqe_back
  import sqe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  output logic        busy_o,
  output logic [6:0]  rd_comp_o,
  output logic [7:0]  rd_slot_o,
  input  logic [31:0] rd_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);
  search_state_e state_q, state_d;
  job_t       job_q;
  logic [7:0] first_q, first_d, count_q, count_d;
  logic [3:0] held_q, held_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;
  logic [7:0] half, pos, idx;
  logic       vge;

  assign half = count_q >> 1;
  assign pos  = first_q + half;
  assign vge  = !(order_key(job_q.value) < order_key(rd_data_i));
  assign rd_comp_o   = job_q.component;
  assign rd_slot_o   = pos;
  assign busy_o      = (state_q != ST_IDLE);
  assign job_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign idx = first_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (job_valid_i) state_d = is_nan(job_i.value) ? ST_DONE : ST_READ;
      ST_READ: state_d = (count_q == 8'd0) ? ST_DONE : ST_CMP;
      ST_CMP:  state_d = ST_READ;
      ST_DONE: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    first_d = first_q;
    count_d = count_q;
    held_d = held_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    case (state_q)
      ST_IDLE: begin
        first_d = 8'd0;
        count_d = job_i.wide ? 8'd255 : 8'd15;
        if (is_nan(job_i.value)) first_d = count_d;
      end
      ST_CMP: begin
        if (vge) begin
          first_d = pos + 8'd1;
          count_d = count_q - half - 8'd1;
        end else begin
          count_d = half;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.vector_last = job_q.last;
          if (job_q.wide) begin
            out_d.code_byte  = idx;
            out_d.byte_index = job_q.component;
            out_valid_d = 1'b1;
          end else if (!job_q.component[0]) begin
            held_d = idx[3:0] & NibbleMask;
            out_d.code_byte  = {4'h0, idx[3:0]};
            out_d.byte_index = job_q.component >> 1;
            out_valid_d = job_q.emit_even;
          end else begin
            out_d.code_byte  = {idx[3:0], held_q};
            out_d.byte_index = job_q.component >> 1;
            out_valid_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      held_q <= 4'h0;
      out_valid_q <= 1'b0;
      first_q <= 8'd0;
      count_q <= 8'd0;
    end else begin
      state_q <= state_d;
      held_q <= held_d;
      out_valid_q <= out_valid_d;
      first_q <= first_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (state_q == ST_IDLE && job_valid_i) job_q <= job_i;
  end
endmodule

FILE: rtl/scalar_quantize_encode_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scalar_quantize_encode_top
// Per-dimension scalar quantizer, encode side.
// ---------------------------------------------------------------------------
// Input words are loads (write one boundary) or encodes (one component).
// A load is taken in any cycle in which the search engine is idle and gives
// no result. An encode below the dimension count is taken into the engine's
// job register (others are dropped); the engine runs an upper-bound binary
// search through one boundary memory read port, each probe a read state and
// a compare state. In 8-bit mode 8 probes, the final check and the packing
// step put the result word out; in 4-bit mode there are 4 probes, and a NaN
// value goes straight to packing. The engine then returns to idle to take
// the next word. The result word sits in an output register; while the
// receiver stalls, the engine holds the finished job and the input stalls
// behind it. Reset clears the control state and the held nibble and sets
// the registers to 8-bit codes and 128 dimensions; the boundary memory is
// undefined until loaded. Configuration writes take effect at once and are
// to be made only when idle by the user; the block does not enforce this.
// ---------------------------------------------------------------------------
module scalar_quantize_encode_top
  import sqe_pkg::*;
#(
  parameter int unsigned MaxDim = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);
  localparam int unsigned DimW = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int unsigned Depth = MaxDim * 256;
  localparam int unsigned AddrW = $clog2(Depth);

  logic       code_width_q;
  logic [7:0] dim_count_q;
  logic       job_valid, job_ready, busy, load_we;
  job_t       job;
  logic [6:0] rd_comp;
  logic [7:0] rd_slot;
  logic [31:0] rd_data;
  logic [AddrW-1:0] addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_width_q <= 1'b1;
      dim_count_q  <= 8'd128;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CODE_WIDTH: code_width_q <= cfg_data_i[0];
        REG_DIM_COUNT:  dim_count_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sqe_front #(.MaxDim(MaxDim)) u_front (
    .in_valid_i, .in_ready_o, .in_data_i,
    .code_width_sel_i(code_width_q), .dim_count_i(dim_count_q),
    .ram_busy_i(busy), .job_ready_i(job_ready),
    .job_valid_o(job_valid), .job_o(job), .load_we_o(load_we)
  );

  sqe_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .busy_o(busy), .rd_comp_o(rd_comp), .rd_slot_o(rd_slot), .rd_data_i(rd_data),
    .out_valid_o, .out_ready_i, .out_data_o
  );

  assign addr = busy ? AddrW'({DimW'(rd_comp), rd_slot})
                     : AddrW'({DimW'(in_data_i.component), in_data_i.slot});

  sqe_ram #(.Width(32), .Depth(Depth)) u_ram (
    .clk_i, .we_i(load_we), .addr_i(addr),
    .wdata_i(in_data_i.value), .rdata_o(rd_data)
  );
endmodule
